/* rtl/brf_pkg.sv */
`default_nettype none

package brf_pkg;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

  // right shift of |b| added to the absolute tolerance
  localparam int TOL_SHIFT = 51;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_EVAL = 2'd0;
  localparam logic [1:0] KIND_ROOT = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // failure codes
  localparam logic [2:0] FAIL_NONE       = 3'd0;
  localparam logic [2:0] FAIL_BOTH_UNDEF = 3'd1;
  localparam logic [2:0] FAIL_NO_DEFINED = 3'd2;
  localparam logic [2:0] FAIL_NO_BRACKET = 3'd3;
  localparam logic [2:0] FAIL_ITER_UNDEF = 3'd4;
  localparam logic [2:0] FAIL_TOO_MANY   = 3'd5;
  localparam logic [2:0] FAIL_UNEXPECTED = 3'd6;

  // search phases
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_EVAL_A0     = 4'd1;
  localparam logic [3:0] PH_EVAL_B0     = 4'd2;
  localparam logic [3:0] PH_BISECT_INIT = 4'd3;
  localparam logic [3:0] PH_EXP_A       = 4'd4;
  localparam logic [3:0] PH_EXP_B       = 4'd5;
  localparam logic [3:0] PH_EXP_ONE     = 4'd6;
  localparam logic [3:0] PH_BISECT_EXP  = 4'd7;
  localparam logic [3:0] PH_ITER        = 4'd8;

  // undefined side
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LOWER = 2'd1;
  localparam logic [1:0] SIDE_UPPER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_ITER  = 2'd0;
  localparam logic [1:0] CFG_MAX_TRIES = 2'd1;
  localparam logic [1:0] CFG_EXP_STEP  = 2'd2;
  localparam logic [1:0] CFG_TOL_ABS   = 2'd3;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic div;
  } mdu_req_t;

endpackage

`default_nettype wire

/* rtl/brf_mdu.sv */
`default_nettype none

// shared fixed point multiply / divide, one bit per cycle, saturating result
module brf_mdu #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire brf_pkg::mdu_req_t req,
  input  wire brf_pkg::fx_t     x,
  input  wire brf_pkg::fx_t     y,
  output logic                  done,
  output brf_pkg::fx_t          res
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

  logic [1:0]    st_r, st_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [127:0]  acc_r, acc_nxt;
  logic [63:0]   rem_r, rem_nxt;
  logic [63:0]   opnd_r, opnd_nxt;
  logic          neg_r, neg_nxt;
  logic          div_r, div_nxt;
  logic          done_r, done_nxt;
  brf_pkg::fx_t  res_r, res_nxt;

  function automatic brf_pkg::fx_t from_mag(input logic neg, input logic [127:0] m);
    logic [63:0] limit;
    logic [63:0] lo;
    limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    lo    = m[63:0];
    if (m[127:64] != 64'd0 || lo > limit) begin
      return neg ? brf_pkg::FX_MIN : brf_pkg::FX_MAX;
    end
    return neg ? brf_pkg::fx_t'(64'd0 - lo) : brf_pkg::fx_t'(lo);
  endfunction

  always_comb begin
    logic [63:0]  xu;
    logic [63:0]  yu;
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [64:0]  sum;
    logic [63:0]  rsh;
    logic         ge;
    logic [127:0] mg;
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    opnd_nxt = opnd_r;
    neg_nxt  = neg_r;
    div_nxt  = div_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    xu  = x;
    yu  = y;
    mx  = x[63] ? 64'd0 - xu : xu;
    my  = y[63] ? 64'd0 - yu : yu;
    sum = {1'b0, acc_r[127:64]} + (acc_r[0] ? {1'b0, opnd_r} : 65'd0);
    rsh = {rem_r[62:0], acc_r[127]};
    ge  = rem_r[63] || (rsh >= opnd_r);
    mg  = div_r ? acc_r : (acc_r >> FRAC_BITS);
    case (st_r)
      U_IDLE: begin
        if (req.start) begin
          neg_nxt = x[63] ^ y[63];
          div_nxt = req.div;
          if (req.div && y == '0) begin
            // divide by zero: zero or the full-scale value of the dividend's sign
            res_nxt  = (x == '0) ? '0 : (x[63] ? brf_pkg::FX_MIN : brf_pkg::FX_MAX);
            done_nxt = 1'b1;
          end else if (req.div) begin
            acc_nxt  = {64'd0, mx} << FRAC_BITS;
            rem_nxt  = '0;
            opnd_nxt = my;
            cnt_nxt  = DIV_LAST;
            st_nxt   = U_DIV;
          end else begin
            acc_nxt  = {64'd0, my};
            opnd_nxt = mx;
            cnt_nxt  = MUL_LAST;
            st_nxt   = U_MUL;
          end
        end
      end
      U_MUL: begin
        acc_nxt = {sum, acc_r[63:1]};
        if (cnt_r == '0) st_nxt = U_FIN;
        else cnt_nxt = cnt_r - 7'd1;
      end
      U_DIV: begin
        rem_nxt = ge ? rsh - opnd_r : rsh;
        acc_nxt = {acc_r[126:0], ge};
        if (cnt_r == '0) st_nxt = U_FIN;
        else cnt_nxt = cnt_r - 7'd1;
      end
      U_FIN: begin
        res_nxt  = from_mag(neg_r, mg);
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    opnd_r <= opnd_nxt;
    neg_r  <= neg_nxt;
    div_r  <= div_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

/* rtl/bracketing_brent_root_finder_top.sv */
// an item that needs no iteration goes from accept through an optional bracket step to emit
// a brent iteration runs up to 4 divides and 9 multiplies, one at a time, on
// the one shared multiply / divide unit
// throughput: one item at a time; the next item is taken once the result is registered
// reset: rst_n synchronous active low; search idle, registers back to their defaults
// (max_iterations 1000, max_bracket_tries 150, expand_step 10.0, tol_abs about 0.001)
`default_nettype none

module bracketing_brent_root_finder_top #(
  parameter int FRAC_BITS = 32  // fraction bits of the fixed point values, 16 to 48
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic signed [63:0] in_lower_bound,
  input  wire logic signed [63:0] in_upper_bound,
  input  wire logic signed [63:0] in_f_value,
  input  wire logic               in_f_defined,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic signed [63:0]      out_point,
  output logic [2:0]              out_fail_code,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [62:0]        cfg_wdata
);

  localparam brf_pkg::fx_t FX_ONE = brf_pkg::fx_t'(64'd1 << FRAC_BITS);

  // sequencer states
  localparam logic [4:0] C_IN      = 5'd0;   // waiting for an item
  localparam logic [4:0] C_EMIT    = 5'd1;   // result waits for the output register
  localparam logic [4:0] C_BRACKET = 5'd2;   // bracket check / widen
  localparam logic [4:0] C_B0      = 5'd3;   // iteration limit, re-bracket
  localparam logic [4:0] C_B1      = 5'd4;   // keep b as best estimate
  localparam logic [4:0] C_B2      = 5'd5;   // tolerance and half gap
  localparam logic [4:0] C_B3      = 5'd6;   // convergence, pick bisection or interpolation
  localparam logic [4:0] C_RATIO   = 5'd7;
  localparam logic [4:0] C_LIN     = 5'd8;
  localparam logic [4:0] C_QA      = 5'd9;
  localparam logic [4:0] C_RB      = 5'd10;
  localparam logic [4:0] C_T1A     = 5'd11;
  localparam logic [4:0] C_T1B     = 5'd12;
  localparam logic [4:0] C_T2      = 5'd13;
  localparam logic [4:0] C_PNUM    = 5'd14;
  localparam logic [4:0] C_QD1     = 5'd15;
  localparam logic [4:0] C_QD2     = 5'd16;
  localparam logic [4:0] C_SIGN    = 5'd17;
  localparam logic [4:0] C_CMP1    = 5'd18;
  localparam logic [4:0] C_CMP2    = 5'd19;
  localparam logic [4:0] C_CMP3    = 5'd20;
  localparam logic [4:0] C_DECIDE  = 5'd21;
  localparam logic [4:0] C_DIVD    = 5'd22;
  localparam logic [4:0] C_MOVE    = 5'd23;
  localparam logic [4:0] C_STEP    = 5'd24;

  // ---------------------------------------------------------------------------
  // saturating fixed point helpers
  // ---------------------------------------------------------------------------
  function automatic brf_pkg::fx_t sat_add(input brf_pkg::fx_t a, input brf_pkg::fx_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? brf_pkg::FX_MIN : brf_pkg::FX_MAX;
    return brf_pkg::fx_t'(s[63:0]);
  endfunction

  function automatic brf_pkg::fx_t sat_sub(input brf_pkg::fx_t a, input brf_pkg::fx_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? brf_pkg::FX_MIN : brf_pkg::FX_MAX;
    return brf_pkg::fx_t'(s[63:0]);
  endfunction

  function automatic brf_pkg::fx_t sat_abs(input brf_pkg::fx_t a);
    if (a == brf_pkg::FX_MIN) return brf_pkg::FX_MAX;
    return a[63] ? -a : a;
  endfunction

  function automatic brf_pkg::fx_t sat_neg(input brf_pkg::fx_t a);
    if (a == brf_pkg::FX_MIN) return brf_pkg::FX_MAX;
    return -a;
  endfunction

  // floor((a + b) / 2), exact
  function automatic brf_pkg::fx_t midpoint(input brf_pkg::fx_t a, input brf_pkg::fx_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    return brf_pkg::fx_t'(s[64:1]);
  endfunction

  // floor((a - b) / 2), exact
  function automatic brf_pkg::fx_t half_diff(input brf_pkg::fx_t a, input brf_pkg::fx_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    return brf_pkg::fx_t'(s[64:1]);
  endfunction

  // both strictly positive or both strictly negative
  function automatic logic same_sign(input brf_pkg::fx_t a, input brf_pkg::fx_t b);
    return (!a[63] && a != '0 && !b[63] && b != '0) || (a[63] && b[63]);
  endfunction

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  logic [4:0]    ctl_r, ctl_nxt;
  logic          issued_r, issued_nxt;
  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    side_r, side_nxt;
  logic [15:0]   loop_cnt_r, loop_cnt_nxt;
  logic [15:0]   tries_cnt_r, tries_cnt_nxt;

  brf_pkg::fx_t  pt_a_r, pt_a_nxt;
  brf_pkg::fx_t  pt_b_r, pt_b_nxt;
  brf_pkg::fx_t  pt_c_r, pt_c_nxt;
  brf_pkg::fx_t  step_d_r, step_d_nxt;
  brf_pkg::fx_t  step_e_r, step_e_nxt;
  brf_pkg::fx_t  val_a_r, val_a_nxt;
  brf_pkg::fx_t  val_b_r, val_b_nxt;
  brf_pkg::fx_t  val_c_r, val_c_nxt;
  brf_pkg::fx_t  bad_pt_r, bad_pt_nxt;
  brf_pkg::fx_t  good_pt_r, good_pt_nxt;

  // iteration scratch
  brf_pkg::fx_t  tolv_r, tolv_nxt;
  brf_pkg::fx_t  hg_r, hg_nxt;
  brf_pkg::fx_t  ratio_r, ratio_nxt;
  brf_pkg::fx_t  qa_r, qa_nxt;
  brf_pkg::fx_t  rb_r, rb_nxt;
  brf_pkg::fx_t  tmp_r, tmp_nxt;
  brf_pkg::fx_t  t1_r, t1_nxt;
  brf_pkg::fx_t  t2_r, t2_nxt;
  brf_pkg::fx_t  pnum_r, pnum_nxt;
  brf_pkg::fx_t  qden_r, qden_nxt;
  brf_pkg::fx_t  olde_r, olde_nxt;

  // pending result
  logic [1:0]    res_kind_r, res_kind_nxt;
  brf_pkg::fx_t  res_point_r, res_point_nxt;
  logic [2:0]    res_code_r, res_code_nxt;

  // output register
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  brf_pkg::fx_t  out_point_r;
  logic [2:0]    out_code_r;

  // configuration
  logic [15:0]   max_iter_r;
  logic [15:0]   max_tries_r;
  logic [62:0]   exp_step_r;
  logic [62:0]   tol_abs_r;

  // shared unit
  brf_pkg::mdu_req_t mdu_req;
  brf_pkg::fx_t      mdu_x;
  brf_pkg::fx_t      mdu_y;
  logic              mdu_done;
  brf_pkg::fx_t      mdu_res;
  logic              unit_state;
  logic              unit_fin;
  logic              slot_free;

  brf_pkg::fx_t      exp_fx;
  brf_pkg::fx_t      tol_fx;

  assign exp_fx    = brf_pkg::fx_t'({1'b0, exp_step_r});
  assign tol_fx    = brf_pkg::fx_t'({1'b0, tol_abs_r});
  assign in_ready  = (ctl_r == C_IN);
  assign slot_free = !out_valid_r || out_ready;
  assign unit_fin  = issued_r && mdu_done;

  // ---------------------------------------------------------------------------
  // operand selection for the shared multiply / divide unit
  // ---------------------------------------------------------------------------
  always_comb begin
    unit_state = 1'b1;
    mdu_req    = '0;
    mdu_x      = '0;
    mdu_y      = '0;
    case (ctl_r)
      C_RATIO: begin mdu_req.div = 1'b1; mdu_x = val_b_r; mdu_y = val_a_r; end
      C_LIN:   begin mdu_x = sat_add(hg_r, hg_r); mdu_y = ratio_r; end
      C_QA:    begin mdu_req.div = 1'b1; mdu_x = val_a_r; mdu_y = val_c_r; end
      C_RB:    begin mdu_req.div = 1'b1; mdu_x = val_b_r; mdu_y = val_c_r; end
      C_T1A:   begin mdu_x = sat_add(hg_r, hg_r); mdu_y = qa_r; end
      C_T1B:   begin mdu_x = tmp_r; mdu_y = sat_sub(qa_r, rb_r); end
      C_T2:    begin mdu_x = sat_sub(pt_b_r, pt_a_r); mdu_y = sat_sub(rb_r, FX_ONE); end
      C_PNUM:  begin mdu_x = ratio_r; mdu_y = sat_sub(t1_r, t2_r); end
      C_QD1:   begin mdu_x = sat_sub(qa_r, FX_ONE); mdu_y = sat_sub(rb_r, FX_ONE); end
      C_QD2:   begin mdu_x = tmp_r; mdu_y = sat_sub(ratio_r, FX_ONE); end
      C_CMP1:  begin mdu_x = t1_r; mdu_y = qden_r; end
      C_CMP2:  begin mdu_x = tolv_r; mdu_y = qden_r; end
      C_CMP3:  begin mdu_x = olde_r >>> 1; mdu_y = qden_r; end
      C_DIVD:  begin mdu_req.div = 1'b1; mdu_x = pnum_r; mdu_y = qden_r; end
      default: unit_state = 1'b0;
    endcase
    mdu_req.start = unit_state && !issued_r;
  end

  brf_mdu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mdu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mdu_req),
    .x    (mdu_x),
    .y    (mdu_y),
    .done (mdu_done),
    .res  (mdu_res)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    brf_pkg::fx_t v;
    brf_pkg::fx_t mid_v;
    brf_pkg::fx_t good_sel;
    brf_pkg::fx_t new_a;
    brf_pkg::fx_t new_b;
    brf_pkg::fx_t ab;
    logic [63:0]  ab_u;
    logic         def;
    logic         cond;

    ctl_nxt       = ctl_r;
    issued_nxt    = issued_r;
    phase_nxt     = phase_r;
    side_nxt      = side_r;
    loop_cnt_nxt  = loop_cnt_r;
    tries_cnt_nxt = tries_cnt_r;
    pt_a_nxt      = pt_a_r;
    pt_b_nxt      = pt_b_r;
    pt_c_nxt      = pt_c_r;
    step_d_nxt    = step_d_r;
    step_e_nxt    = step_e_r;
    val_a_nxt     = val_a_r;
    val_b_nxt     = val_b_r;
    val_c_nxt     = val_c_r;
    bad_pt_nxt    = bad_pt_r;
    good_pt_nxt   = good_pt_r;
    tolv_nxt      = tolv_r;
    hg_nxt        = hg_r;
    ratio_nxt     = ratio_r;
    qa_nxt        = qa_r;
    rb_nxt        = rb_r;
    tmp_nxt       = tmp_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    pnum_nxt      = pnum_r;
    qden_nxt      = qden_r;
    olde_nxt      = olde_r;
    res_kind_nxt  = res_kind_r;
    res_point_nxt = res_point_r;
    res_code_nxt  = res_code_r;

    v        = in_f_value;
    def      = in_f_defined;
    mid_v    = midpoint(pt_c_r, good_pt_r);
    good_sel = (side_r == brf_pkg::SIDE_LOWER) ? pt_a_r : pt_b_r;
    new_a    = sat_sub(pt_a_r, exp_fx);
    new_b    = sat_add(pt_b_r, exp_fx);
    ab       = sat_abs(pt_b_r);
    ab_u     = ab;
    cond     = 1'b0;

    if (mdu_req.start) issued_nxt = 1'b1;
    if (unit_fin) issued_nxt = 1'b0;

    case (ctl_r)
      C_IN: begin
        if (in_valid) begin
          // result defaults to an evaluation request
          ctl_nxt      = C_EMIT;
          res_kind_nxt = brf_pkg::KIND_EVAL;
          res_code_nxt = brf_pkg::FAIL_NONE;
          if (in_operation == brf_pkg::OP_START) begin
            // start always restarts the search
            pt_a_nxt      = in_lower_bound;
            pt_b_nxt      = in_upper_bound;
            side_nxt      = brf_pkg::SIDE_NONE;
            loop_cnt_nxt  = '0;
            tries_cnt_nxt = '0;
            phase_nxt     = brf_pkg::PH_EVAL_A0;
            res_point_nxt = in_lower_bound;
          end else begin
            case (phase_r)
              brf_pkg::PH_EVAL_A0: begin
                val_a_nxt     = v;
                side_nxt      = def ? brf_pkg::SIDE_NONE : brf_pkg::SIDE_LOWER;
                phase_nxt     = brf_pkg::PH_EVAL_B0;
                res_point_nxt = pt_b_r;
              end
              brf_pkg::PH_EVAL_B0: begin
                val_b_nxt = v;
                if (!def && side_r == brf_pkg::SIDE_LOWER) begin
                  phase_nxt     = brf_pkg::PH_IDLE;
                  res_kind_nxt  = brf_pkg::KIND_FAIL;
                  res_point_nxt = '0;
                  res_code_nxt  = brf_pkg::FAIL_BOTH_UNDEF;
                end else if (!def || side_r == brf_pkg::SIDE_LOWER) begin
                  // bisect from the undefined bound toward the defined one
                  if (!def) begin
                    side_nxt    = brf_pkg::SIDE_UPPER;
                    good_pt_nxt = pt_a_r;
                    bad_pt_nxt  = pt_b_r;
                  end else begin
                    bad_pt_nxt  = pt_a_r;
                    good_pt_nxt = pt_b_r;
                  end
                  phase_nxt     = brf_pkg::PH_BISECT_INIT;
                  pt_c_nxt      = midpoint(pt_a_r, pt_b_r);
                  loop_cnt_nxt  = '0;
                  res_point_nxt = midpoint(pt_a_r, pt_b_r);
                end else begin
                  tries_cnt_nxt = '0;
                  ctl_nxt       = C_BRACKET;
                end
              end
              brf_pkg::PH_BISECT_INIT, brf_pkg::PH_BISECT_EXP: begin
                if (!def) begin
                  if (loop_cnt_r < max_iter_r) begin
                    bad_pt_nxt    = pt_c_r;
                    pt_c_nxt      = mid_v;
                    loop_cnt_nxt  = loop_cnt_r + 16'd1;
                    res_point_nxt = mid_v;
                  end else begin
                    phase_nxt     = brf_pkg::PH_IDLE;
                    res_kind_nxt  = brf_pkg::KIND_FAIL;
                    res_point_nxt = '0;
                    res_code_nxt  = brf_pkg::FAIL_NO_DEFINED;
                  end
                end else begin
                  if (side_r == brf_pkg::SIDE_LOWER) begin
                    pt_a_nxt  = pt_c_r;
                    val_a_nxt = v;
                  end else begin
                    pt_b_nxt  = pt_c_r;
                    val_b_nxt = v;
                  end
                  if (phase_r == brf_pkg::PH_BISECT_EXP) tries_cnt_nxt = tries_cnt_r + 16'd1;
                  ctl_nxt = C_BRACKET;
                end
              end
              brf_pkg::PH_EXP_A: begin
                if (!def) begin
                  phase_nxt     = brf_pkg::PH_IDLE;
                  res_kind_nxt  = brf_pkg::KIND_FAIL;
                  res_point_nxt = '0;
                  res_code_nxt  = brf_pkg::FAIL_NO_DEFINED;
                end else begin
                  val_a_nxt     = v;
                  phase_nxt     = brf_pkg::PH_EXP_B;
                  res_point_nxt = pt_b_r;
                end
              end
              brf_pkg::PH_EXP_B: begin
                if (!def) begin
                  phase_nxt     = brf_pkg::PH_IDLE;
                  res_kind_nxt  = brf_pkg::KIND_FAIL;
                  res_point_nxt = '0;
                  res_code_nxt  = brf_pkg::FAIL_NO_DEFINED;
                end else begin
                  val_b_nxt     = v;
                  tries_cnt_nxt = tries_cnt_r + 16'd1;
                  ctl_nxt       = C_BRACKET;
                end
              end
              brf_pkg::PH_EXP_ONE: begin
                if (!def) begin
                  phase_nxt     = brf_pkg::PH_IDLE;
                  res_kind_nxt  = brf_pkg::KIND_FAIL;
                  res_point_nxt = '0;
                  res_code_nxt  = brf_pkg::FAIL_NO_DEFINED;
                end else begin
                  // moved bound is defined: bisect back toward the undefined side
                  if (side_r == brf_pkg::SIDE_LOWER) val_b_nxt = v;
                  else val_a_nxt = v;
                  good_pt_nxt   = good_sel;
                  phase_nxt     = brf_pkg::PH_BISECT_EXP;
                  pt_c_nxt      = midpoint(bad_pt_r, good_sel);
                  loop_cnt_nxt  = '0;
                  res_point_nxt = midpoint(bad_pt_r, good_sel);
                end
              end
              brf_pkg::PH_ITER: begin
                if (!def) begin
                  phase_nxt     = brf_pkg::PH_IDLE;
                  res_kind_nxt  = brf_pkg::KIND_FAIL;
                  res_point_nxt = '0;
                  res_code_nxt  = brf_pkg::FAIL_ITER_UNDEF;
                end else begin
                  val_b_nxt    = v;
                  loop_cnt_nxt = loop_cnt_r + 16'd1;
                  ctl_nxt      = C_B0;
                end
              end
              default: begin
                // evaluation with no search running
                phase_nxt     = brf_pkg::PH_IDLE;
                res_kind_nxt  = brf_pkg::KIND_FAIL;
                res_point_nxt = '0;
                res_code_nxt  = brf_pkg::FAIL_UNEXPECTED;
              end
            endcase
          end
        end
      end

      C_EMIT: begin
        if (slot_free) ctl_nxt = C_IN;
      end

      C_BRACKET: begin
        ctl_nxt      = C_EMIT;
        res_kind_nxt = brf_pkg::KIND_EVAL;
        res_code_nxt = brf_pkg::FAIL_NONE;
        if (!same_sign(val_a_r, val_b_r)) begin
          // sign change or a zero: bracketed, start iterating
          val_c_nxt    = val_b_r;
          loop_cnt_nxt = '0;
          ctl_nxt      = C_B0;
        end else if (tries_cnt_r >= max_tries_r) begin
          phase_nxt     = brf_pkg::PH_IDLE;
          res_kind_nxt  = brf_pkg::KIND_FAIL;
          res_point_nxt = '0;
          res_code_nxt  = brf_pkg::FAIL_NO_BRACKET;
        end else if (side_r == brf_pkg::SIDE_NONE) begin
          pt_a_nxt      = new_a;
          pt_b_nxt      = new_b;
          phase_nxt     = brf_pkg::PH_EXP_A;
          res_point_nxt = new_a;
        end else begin
          // only the defined side moves
          phase_nxt = brf_pkg::PH_EXP_ONE;
          if (side_r == brf_pkg::SIDE_LOWER) begin
            pt_b_nxt      = new_b;
            res_point_nxt = new_b;
          end else begin
            pt_a_nxt      = new_a;
            res_point_nxt = new_a;
          end
        end
      end

      C_B0: begin
        if (loop_cnt_r >= max_iter_r) begin
          phase_nxt     = brf_pkg::PH_IDLE;
          res_kind_nxt  = brf_pkg::KIND_FAIL;
          res_point_nxt = '0;
          res_code_nxt  = brf_pkg::FAIL_TOO_MANY;
          ctl_nxt       = C_EMIT;
        end else begin
          if (same_sign(val_b_r, val_c_r)) begin
            pt_c_nxt   = pt_a_r;
            val_c_nxt  = val_a_r;
            step_d_nxt = sat_sub(pt_b_r, pt_a_r);
            step_e_nxt = sat_sub(pt_b_r, pt_a_r);
          end
          ctl_nxt = C_B1;
        end
      end

      C_B1: begin
        if (sat_abs(val_c_r) < sat_abs(val_b_r)) begin
          pt_a_nxt  = pt_b_r;
          pt_b_nxt  = pt_c_r;
          pt_c_nxt  = pt_b_r;
          val_a_nxt = val_b_r;
          val_b_nxt = val_c_r;
          val_c_nxt = val_b_r;
        end
        ctl_nxt = C_B2;
      end

      C_B2: begin
        tolv_nxt = sat_add(tol_fx, brf_pkg::fx_t'(ab_u >> brf_pkg::TOL_SHIFT));
        hg_nxt   = half_diff(pt_c_r, pt_b_r);
        ctl_nxt  = C_B3;
      end

      C_B3: begin
        if (sat_abs(hg_r) <= tolv_r || val_b_r == '0) begin
          phase_nxt     = brf_pkg::PH_IDLE;
          res_kind_nxt  = brf_pkg::KIND_ROOT;
          res_point_nxt = pt_b_r;
          res_code_nxt  = brf_pkg::FAIL_NONE;
          ctl_nxt       = C_EMIT;
        end else if (sat_abs(step_e_r) < tolv_r || sat_abs(val_a_r) <= sat_abs(val_b_r)) begin
          step_d_nxt = hg_r;
          step_e_nxt = hg_r;
          ctl_nxt    = C_MOVE;
        end else begin
          ctl_nxt = C_RATIO;
        end
      end

      C_RATIO: if (unit_fin) begin
        ratio_nxt = mdu_res;
        ctl_nxt   = (pt_a_r == pt_c_r) ? C_LIN : C_QA;
      end

      // secant step
      C_LIN: if (unit_fin) begin
        pnum_nxt = mdu_res;
        qden_nxt = sat_sub(FX_ONE, ratio_r);
        ctl_nxt  = C_SIGN;
      end

      // inverse quadratic step
      C_QA:   if (unit_fin) begin qa_nxt = mdu_res;   ctl_nxt = C_RB;   end
      C_RB:   if (unit_fin) begin rb_nxt = mdu_res;   ctl_nxt = C_T1A;  end
      C_T1A:  if (unit_fin) begin tmp_nxt = mdu_res;  ctl_nxt = C_T1B;  end
      C_T1B:  if (unit_fin) begin t1_nxt = mdu_res;   ctl_nxt = C_T2;   end
      C_T2:   if (unit_fin) begin t2_nxt = mdu_res;   ctl_nxt = C_PNUM; end
      C_PNUM: if (unit_fin) begin pnum_nxt = mdu_res; ctl_nxt = C_QD1;  end
      C_QD1:  if (unit_fin) begin tmp_nxt = mdu_res;  ctl_nxt = C_QD2;  end
      C_QD2:  if (unit_fin) begin qden_nxt = mdu_res; ctl_nxt = C_SIGN; end

      C_SIGN: begin
        if (pnum_r > 0) qden_nxt = sat_neg(qden_r);
        else pnum_nxt = sat_neg(pnum_r);
        olde_nxt   = step_e_r;
        step_e_nxt = step_d_r;
        // 3 * half gap for the acceptance test
        t1_nxt     = sat_add(sat_add(hg_r, hg_r), hg_r);
        ctl_nxt    = C_CMP1;
      end

      C_CMP1: if (unit_fin) begin tmp_nxt = mdu_res; ctl_nxt = C_CMP2; end
      C_CMP2: if (unit_fin) begin
        t1_nxt  = sat_sub(tmp_r, sat_abs(mdu_res));
        ctl_nxt = C_CMP3;
      end
      C_CMP3: if (unit_fin) begin t2_nxt = mdu_res; ctl_nxt = C_DECIDE; end

      C_DECIDE: begin
        cond = (sat_add(pnum_r, pnum_r) < t1_r) && (pnum_r < sat_abs(t2_r));
        if (cond) begin
          ctl_nxt = C_DIVD;
        end else begin
          // interpolation rejected: fall back to bisection
          step_d_nxt = hg_r;
          step_e_nxt = hg_r;
          ctl_nxt    = C_MOVE;
        end
      end

      C_DIVD: if (unit_fin) begin step_d_nxt = mdu_res; ctl_nxt = C_MOVE; end

      C_MOVE: begin
        pt_a_nxt  = pt_b_r;
        val_a_nxt = val_b_r;
        if (sat_abs(step_d_r) > tolv_r) tmp_nxt = step_d_r;
        else tmp_nxt = (hg_r > 0) ? tolv_r : -tolv_r;
        ctl_nxt = C_STEP;
      end

      C_STEP: begin
        pt_b_nxt      = sat_add(pt_b_r, tmp_r);
        phase_nxt     = brf_pkg::PH_ITER;
        res_kind_nxt  = brf_pkg::KIND_EVAL;
        res_point_nxt = sat_add(pt_b_r, tmp_r);
        res_code_nxt  = brf_pkg::FAIL_NONE;
        ctl_nxt       = C_EMIT;
      end

      default: ctl_nxt = C_IN;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= C_IN;
      issued_r <= 1'b0;
      phase_r  <= brf_pkg::PH_IDLE;
      side_r   <= brf_pkg::SIDE_NONE;
    end else begin
      ctl_r    <= ctl_nxt;
      issued_r <= issued_nxt;
      phase_r  <= phase_nxt;
      side_r   <= side_nxt;
    end
  end

  // search data and scratch
  always_ff @(posedge clk) begin
    loop_cnt_r  <= loop_cnt_nxt;
    tries_cnt_r <= tries_cnt_nxt;
    pt_a_r      <= pt_a_nxt;
    pt_b_r      <= pt_b_nxt;
    pt_c_r      <= pt_c_nxt;
    step_d_r    <= step_d_nxt;
    step_e_r    <= step_e_nxt;
    val_a_r     <= val_a_nxt;
    val_b_r     <= val_b_nxt;
    val_c_r     <= val_c_nxt;
    bad_pt_r    <= bad_pt_nxt;
    good_pt_r   <= good_pt_nxt;
    tolv_r      <= tolv_nxt;
    hg_r        <= hg_nxt;
    ratio_r     <= ratio_nxt;
    qa_r        <= qa_nxt;
    rb_r        <= rb_nxt;
    tmp_r       <= tmp_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    pnum_r      <= pnum_nxt;
    qden_r      <= qden_nxt;
    olde_r      <= olde_nxt;
    res_kind_r  <= res_kind_nxt;
    res_point_r <= res_point_nxt;
    res_code_r  <= res_code_nxt;
  end

  // output register, loaded from the pending result when the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_r == C_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r == C_EMIT && slot_free) begin
      out_kind_r  <= res_kind_r;
      out_point_r <= res_point_r;
      out_code_r  <= res_code_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= 16'd1000;
      max_tries_r <= 16'd150;
      exp_step_r  <= 63'd42949672960;
      tol_abs_r   <= 63'd4294967;
    end else if (cfg_we) begin
      case (cfg_idx)
        brf_pkg::CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[15:0];
        brf_pkg::CFG_MAX_TRIES: max_tries_r <= cfg_wdata[15:0];
        brf_pkg::CFG_EXP_STEP:  exp_step_r  <= cfg_wdata;
        brf_pkg::CFG_TOL_ABS:   tol_abs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_point     = out_point_r;
  assign out_fail_code = out_code_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_only_when_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> issued_r)
    else $error("unit finished without a pending request");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == C_EMIT && slot_free) |=> (out_valid_r && ctl_r == C_IN))
    else $error("pending result not moved to the output register");

  a_fail_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == brf_pkg::KIND_FAIL) |->
      (out_point_r == '0 && out_code_r != brf_pkg::FAIL_NONE))
    else $error("failure result with a point or no code");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (issued_r || unit_state) |-> !in_ready)
    else $error("input taken while an iteration is running");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire
